// File: src/citi_pkg.sv
// ----------------------------------------------------------------------------
// citi_pkg: shared constants for the complex index table interpolator
// Table ROM (wavelength Q2.16, real and imaginary index Q3.13), field widths
// and pipeline sizes.
// ----------------------------------------------------------------------------
package citi_pkg;

  localparam int WL_W  = 18;
  localparam int IDX_W = 16;
  localparam int DEN_W = 17;
  localparam int NUM_W = 32;
  localparam int PRD_W = IDX_W + DEN_W;

  localparam int ROM_ROWS    = 31;
  localparam int ENTRY_COUNT = 31;
  localparam int ACTIVE_ROWS = (ENTRY_COUNT < 2) ? 2 :
                               ((ENTRY_COUNT > ROM_ROWS) ? ROM_ROWS : ENTRY_COUNT);
  localparam int SEG_W = $clog2(ROM_ROWS);

  localparam int DIV_STEPS = IDX_W;

  localparam int S_TDATA_W = ((WL_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;

  localparam logic [WL_W-1:0] ROM_WL [ROM_ROWS] = '{
    18'd4063,  18'd5420,  18'd8126,  18'd9031,  18'd10158, 18'd11606,
    18'd13540, 18'd14772, 18'd16253, 18'd18055, 18'd20316, 18'd23213,
    18'd27086, 18'd28017, 18'd29019, 18'd30094, 18'd31254, 18'd32499,
    18'd33856, 18'd35330, 18'd36936, 18'd38692, 18'd40626, 18'd42769,
    18'd45141, 18'd47795, 18'd50784, 18'd54172, 18'd58039, 18'd65536,
    18'd131072
  };

  localparam logic [IDX_W-1:0] ROM_RE [ROM_ROWS] = '{
    16'd8397,  16'd6849,  16'd7479,  16'd7381,  16'd7365,  16'd8708,
    16'd10355, 16'd11330, 16'd18620, 16'd32055, 16'd29499, 16'd28926,
    16'd36938, 16'd41386, 16'd40624, 16'd38453, 16'd36798, 16'd35496,
    16'd34447, 16'd33587, 16'd32874, 16'd31982, 16'd31769, 16'd31343,
    16'd31007, 16'd30654, 16'd30310, 16'd30032, 16'd29606, 16'd28746,
    16'd28746
  };

  localparam logic [IDX_W-1:0] ROM_IM [ROM_ROWS] = '{
    16'd1180,  16'd2310,  16'd7979,  16'd9306,  16'd11756, 16'd15057,
    16'd20251, 16'd24052, 16'd33456, 16'd23912, 16'd15729, 16'd16490,
    16'd15958, 16'd14098, 16'd8118,  16'd5702,  16'd4415,  16'd3613,
    16'd3039,  16'd2621,  16'd2261,  16'd1966,  16'd1729,  16'd1466,
    16'd1237,  16'd918,   16'd745,   16'd655,   16'd16,    16'd1,
    16'd0
  };

endpackage

// File: src/complex_index_table_interpolator.sv
// ----------------------------------------------------------------------------
// complex_index_table_interpolator: piecewise linear refractive index lookup
// Wavelength in, interpolated complex index out, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per wavelength query, tdata[17:0] = wavelength (Q2.16).
//   m_axis: one item per query, tdata[15:0] = index_real, tdata[31:16] =
//   index_imag (both Q3.13, rounded to nearest, ties up).
//   Queries outside the table return the nearest end row.
//   From acceptance to m_axis, a query passes through these stages in order:
//   segment search, row fetch, multiply, sum, then a 16-stage restoring
//   divider that retires one quotient bit per stage for both parts.
//   Throughput is one item per cycle unless m_axis stalls; every stage is
//   registered and carries a valid bit.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; empty stages do not collapse.
//   Reset clears all valid bits; the table is constant and needs no setup.
// ----------------------------------------------------------------------------
module complex_index_table_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [citi_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [17:0] wavelength
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [citi_pkg::M_TDATA_W-1:0] m_axis_tdata   // [15:0] re, [31:16] im
);
  import citi_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] r_re;
    logic [IDX_W-1:0] r_im;
    logic [IDX_W-1:0] w_re;
    logic [IDX_W-1:0] w_im;
    logic [DEN_W-1:0] den;
  } div_stage_t;

  logic en;

  // stage 1: segment search
  logic [WL_W-1:0]        x;
  logic [ACTIVE_ROWS-1:0] ge;
  logic [SEG_W-1:0]       seg_hit;
  logic                   below, above;
  logic                   v1_q;
  logic [WL_W-1:0]        x1_q;
  logic [SEG_W-1:0]       seg1_d, seg1_q;
  logic                   clamp1_q;

  // stage 2: row fetch and distances
  logic [SEG_W-1:0] hi_idx;
  logic [WL_W-1:0]  d1_full, d2_full;
  logic             v2_q;
  logic [IDX_W-1:0] re_a_q, re_b_q, im_a_q, im_b_q;
  logic [DEN_W-1:0] d1_q, d2_q;

  // stage 3: products
  logic             v3_q;
  logic [PRD_W-1:0] p_re_a_q, p_re_b_q, p_im_a_q, p_im_b_q;
  logic [DEN_W-1:0] den3_q;

  // stage 4: numerators, then divider
  logic [PRD_W:0]   sum_re, sum_im;
  logic [NUM_W-1:0] num_re, num_im;
  div_stage_t       dv_q [DIV_STEPS+1];
  logic             dvv_q [DIV_STEPS+1];

  assign en            = !dvv_q[DIV_STEPS] || m_axis_tready;
  assign s_axis_tready = en;
  assign x             = s_axis_tdata[WL_W-1:0];

  always_comb begin
    for (int i = 0; i < ACTIVE_ROWS; i++) begin
      ge[i] = (x >= ROM_WL[i]);
    end
    seg_hit = '0;
    for (int i = 0; i < ACTIVE_ROWS - 1; i++) begin
      if (i == ACTIVE_ROWS - 2) begin
        if (ge[i]) seg_hit = seg_hit | SEG_W'(i);
      end else begin
        if (ge[i] && !ge[i+1]) seg_hit = seg_hit | SEG_W'(i);
      end
    end
    below = !ge[0];
    above = (x > ROM_WL[ACTIVE_ROWS-1]);
    if (below) begin
      seg1_d = '0;
    end else if (above) begin
      seg1_d = SEG_W'(ACTIVE_ROWS - 1);
    end else begin
      seg1_d = seg_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= x;
      seg1_q   <= seg1_d;
      clamp1_q <= below || above;
    end
  end

  assign hi_idx  = clamp1_q ? seg1_q : seg1_q + SEG_W'(1);
  assign d1_full = x1_q - ROM_WL[seg1_q];
  assign d2_full = ROM_WL[hi_idx] - x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_a_q <= ROM_RE[seg1_q];
      im_a_q <= ROM_IM[seg1_q];
      re_b_q <= ROM_RE[hi_idx];
      im_b_q <= ROM_IM[hi_idx];
      d1_q   <= clamp1_q ? '0 : d1_full[DEN_W-1:0];
      d2_q   <= clamp1_q ? DEN_W'(1) : d2_full[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_re_a_q <= PRD_W'(re_a_q) * PRD_W'(d2_q);
      p_re_b_q <= PRD_W'(re_b_q) * PRD_W'(d1_q);
      p_im_a_q <= PRD_W'(im_a_q) * PRD_W'(d2_q);
      p_im_b_q <= PRD_W'(im_b_q) * PRD_W'(d1_q);
      den3_q   <= d1_q + d2_q;
    end
  end

  // numerator stays below 2^32 since the weights sum to den <= 2^16
  assign sum_re = {1'b0, p_re_a_q} + {1'b0, p_re_b_q} + (PRD_W+1)'(den3_q >> 1);
  assign sum_im = {1'b0, p_im_a_q} + {1'b0, p_im_b_q} + (PRD_W+1)'(den3_q >> 1);
  assign num_re = sum_re[NUM_W-1:0];
  assign num_im = sum_im[NUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= v3_q;
    end
  end

  // quotient fits 16 bits, so the upper numerator half is already below den
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].r_re <= num_re[NUM_W-1:IDX_W];
      dv_q[0].w_re <= num_re[IDX_W-1:0];
      dv_q[0].r_im <= num_im[NUM_W-1:IDX_W];
      dv_q[0].w_im <= num_im[IDX_W-1:0];
      dv_q[0].den  <= den3_q;
    end
  end

  // one quotient bit per stage; quotient bits shift in as numerator bits leave
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [IDX_W:0] t_re, t_im;
    logic           q_re, q_im;
    logic [IDX_W:0] s_re, s_im;
    div_stage_t     nxt_d;

    always_comb begin
      t_re  = {dv_q[k].r_re, dv_q[k].w_re[IDX_W-1]};
      t_im  = {dv_q[k].r_im, dv_q[k].w_im[IDX_W-1]};
      q_re  = (t_re >= dv_q[k].den);
      q_im  = (t_im >= dv_q[k].den);
      s_re  = q_re ? (t_re - dv_q[k].den) : t_re;
      s_im  = q_im ? (t_im - dv_q[k].den) : t_im;
      nxt_d.r_re = s_re[IDX_W-1:0];
      nxt_d.r_im = s_im[IDX_W-1:0];
      nxt_d.w_re = {dv_q[k].w_re[IDX_W-2:0], q_re};
      nxt_d.w_im = {dv_q[k].w_im[IDX_W-2:0], q_im};
      nxt_d.den  = dv_q[k].den;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (en) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= nxt_d;
      end
    end
  end

  assign m_axis_tvalid = dvv_q[DIV_STEPS];
  assign m_axis_tdata  = M_TDATA_W'({dv_q[DIV_STEPS].w_im, dv_q[DIV_STEPS].w_re});

endmodule
